// ----- sv/rgb_morphology_by_luma_unit_macros.svh -----
// Assertion macros for the luma ranked morphology unit.
// Depends on a clk and an active low rst_n being visible where a macro is used.
`ifndef RGB_MORPHOLOGY_BY_LUMA_UNIT_MACROS_SVH
`define RGB_MORPHOLOGY_BY_LUMA_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RMBL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rmbl_pkg.sv -----
// Shared types, constants and the luma helper of the luma ranked morphology unit.
// No dependencies.
`timescale 1ns / 1ps

package rmbl_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_KERNEL = 9;

    // Field widths
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int HEIGHT_W   = 13;
    localparam int SUM_W      = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SELECT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH   = 3'd4;

    // Register reset values
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [2:0]  RST_BORDER_WIDTH = 3'd4;

    // Geometry limits
    localparam int IMAGE_WIDTH_MIN  = 16;
    localparam int IMAGE_HEIGHT_MIN = 16;
    localparam int IMAGE_HEIGHT_MAX = 4096;
    localparam int KERNEL_SMALL     = 5;
    localparam int KERNEL_LARGE     = 9;

    // Divide by three as multiply by 683 / 2048, exact for sums up to 765
    localparam int LUMA_RECIP = 683;
    localparam int LUMA_SHIFT = 11;

    // Result queue depth
    localparam int RQ_DEPTH = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic              drain;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_pixel;
    } res_t;

    // Per-column control from the front end
    typedef struct packed {
        logic valid;
        logic emit;
        logic border;
        logic last;
        logic mode;
    } fe_ctl_t;

    function automatic logic [CHAN_W-1:0] luma3(input logic [SUM_W-1:0] sum);
        logic [20:0] prod;
        prod = 21'(sum) * 21'(LUMA_RECIP);
        return prod[LUMA_SHIFT+CHAN_W-1:LUMA_SHIFT];
    endfunction

endpackage

// ----- sv/rmbl_front.sv -----
// Front end: request intake, configuration, frame counters, line store and column fetch.
// Depends on rmbl_pkg.
`timescale 1ns / 1ps

module rmbl_front #(
    parameter int MAX_WIDTH  = rmbl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = rmbl_pkg::DEF_MAX_KERNEL,
    localparam int NROW      = 2 * ((MAX_KERNEL - 1) / 2) + 1
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    input  logic [rmbl_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [rmbl_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                     push,
    input  logic                                     full,
    input  rmbl_pkg::pix_in_t                        pixel,
    output rmbl_pkg::fe_ctl_t                        ctl,
    output logic [NROW-1:0]                          row_mask,
    output logic [NROW-1:0]                          col_mask,
    output logic [NROW-1:0][rmbl_pkg::PIX_W-1:0]     col_px
);
    import rmbl_pkg::*;

    localparam int HMAX       = (MAX_KERNEL - 1) / 2;
    localparam int KW         = $clog2(NROW);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HALF_SMALL = (HMAX < KERNEL_SMALL / 2) ? HMAX : KERNEL_SMALL / 2;
    localparam int HALF_LARGE = (HMAX < KERNEL_LARGE / 2) ? HMAX : KERNEL_LARGE / 2;
    localparam int RST_W_SAT  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    // Live registers
    logic [11:0]         img_w_reg;
    logic [12:0]         img_h_reg;
    logic                mode_reg;
    logic                ksel_reg;
    logic [2:0]          border_reg;

    // Values held for the running frame
    logic [WW-1:0]       fr_w_reg, fr_w_next;
    logic [HEIGHT_W-1:0] fr_h_reg, fr_h_next;
    logic                fr_mode_reg, fr_mode_next;
    logic [KW-1:0]       fr_half_reg, fr_half_next;
    logic [2:0]          fr_border_reg, fr_border_next;

    // Raster position of the next item and of the next result
    logic [XW-1:0]       x_reg, x_next;
    logic [HEIGHT_W-1:0] y_reg, y_next;
    logic [XW-1:0]       ex_reg, ex_next;
    logic [HEIGHT_W-1:0] ey_reg, ey_next;
    logic [KW-1:0]       ptr_reg, ptr_next;

    logic [WW-1:0]       sat_w;
    logic [HEIGHT_W-1:0] sat_h;
    logic [KW-1:0]       sat_half;
    logic                accept, idle, latch_now, tail, real_px, adv, emit, last, border;
    logic [PIX_W-1:0]    wr_px;
    logic [NROW-1:0]     row_mask_next, col_mask_next;

    // Stage one registers
    fe_ctl_t             ctl_reg;
    logic [NROW-1:0]     row_mask_reg, col_mask_reg;
    logic [PIX_W-1:0]    pix_s1_reg;
    logic [KW-1:0]       ptr_s1_reg;
    logic [PIX_W-1:0]    rd_vec [NROW];

    assign accept = push && !full;
    assign wr_px  = {pixel.in_red, pixel.in_green, pixel.in_blue};

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= RST_IMAGE_WIDTH;
            img_h_reg  <= RST_IMAGE_HEIGHT;
            mode_reg   <= 1'b0;
            ksel_reg   <= 1'b0;
            border_reg <= RST_BORDER_WIDTH;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    img_w_reg  <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT:   img_h_reg  <= cfg_data[12:0];
                CFG_OPERATION_MODE: mode_reg   <= cfg_data[0];
                CFG_KERNEL_SELECT:  ksel_reg   <= cfg_data[0];
                CFG_BORDER_WIDTH:   border_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry and pick the half size
    always_comb
    begin
        if (32'(img_w_reg) > MAX_WIDTH)
            sat_w = WW'(MAX_WIDTH);
        else if (32'(img_w_reg) < IMAGE_WIDTH_MIN)
            sat_w = WW'(IMAGE_WIDTH_MIN);
        else
            sat_w = WW'(img_w_reg);
        if (32'(img_h_reg) > IMAGE_HEIGHT_MAX)
            sat_h = HEIGHT_W'(IMAGE_HEIGHT_MAX);
        else if (32'(img_h_reg) < IMAGE_HEIGHT_MIN)
            sat_h = HEIGHT_W'(IMAGE_HEIGHT_MIN);
        else
            sat_h = img_h_reg;
        sat_half = ksel_reg ? KW'(HALF_LARGE) : KW'(HALF_SMALL);
    end

    // Classify the request and advance the counters
    always_comb
    begin
        idle      = (x_reg == '0) && (y_reg == '0) && (ex_reg == '0) && (ey_reg == '0);
        latch_now = accept && !pixel.drain && idle;

        fr_w_next      = latch_now ? sat_w      : fr_w_reg;
        fr_h_next      = latch_now ? sat_h      : fr_h_reg;
        fr_mode_next   = latch_now ? mode_reg   : fr_mode_reg;
        fr_half_next   = latch_now ? sat_half   : fr_half_reg;
        fr_border_next = latch_now ? border_reg : fr_border_reg;

        tail    = y_reg >= fr_h_next;
        real_px = accept && !pixel.drain && !tail;
        adv     = real_px || (accept && tail);
        emit    = adv && ((32'(y_reg) > 32'(fr_half_next)) ||
                          ((32'(y_reg) == 32'(fr_half_next)) &&
                           (32'(x_reg) >= 32'(fr_half_next))));
        last    = (32'(ex_reg) + 1 == 32'(fr_w_next)) && (32'(ey_reg) + 1 == 32'(fr_h_next));
        border  = (32'(ex_reg) < 32'(fr_border_next)) ||
                  (32'(ex_reg) + 32'(fr_border_next) >= 32'(fr_w_next)) ||
                  (32'(ey_reg) < 32'(fr_border_next)) ||
                  (32'(ey_reg) + 32'(fr_border_next) >= 32'(fr_h_next));

        for (int r = 0; r < NROW; r++)
        begin
            row_mask_next[r] = (r <= 2 * int'(fr_half_next)) && (r <= int'(y_reg)) &&
                               (int'(y_reg) - r < int'(fr_h_next));
            col_mask_next[r] = (r <= 2 * int'(fr_half_next)) &&
                               (int'(ex_reg) + int'(fr_half_next) >= r) &&
                               (int'(ex_reg) + int'(fr_half_next) - r < int'(fr_w_next));
        end

        x_next   = x_reg;
        y_next   = y_reg;
        ex_next  = ex_reg;
        ey_next  = ey_reg;
        ptr_next = ptr_reg;
        if (adv)
        begin
            if (32'(x_reg) + 1 >= 32'(fr_w_next))
            begin
                x_next   = '0;
                y_next   = y_reg + 1'b1;
                ptr_next = (ptr_reg == KW'(NROW - 1)) ? '0 : ptr_reg + 1'b1;
            end
            else
                x_next = x_reg + 1'b1;
            if (emit)
            begin
                if (32'(ex_reg) + 1 >= 32'(fr_w_next))
                begin
                    ex_next = '0;
                    ey_next = ey_reg + 1'b1;
                end
                else
                    ex_next = ex_reg + 1'b1;
            end
            // Frame done: return to the start
            if (emit && last)
            begin
                x_next   = '0;
                y_next   = '0;
                ex_next  = '0;
                ey_next  = '0;
                ptr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_w_reg      <= WW'(RST_W_SAT);
            fr_h_reg      <= RST_IMAGE_HEIGHT;
            fr_mode_reg   <= 1'b0;
            fr_half_reg   <= KW'(HALF_SMALL);
            fr_border_reg <= RST_BORDER_WIDTH;
            x_reg         <= '0;
            y_reg         <= '0;
            ex_reg        <= '0;
            ey_reg        <= '0;
            ptr_reg       <= '0;
            ctl_reg       <= '0;
        end
        else
        begin
            fr_w_reg      <= fr_w_next;
            fr_h_reg      <= fr_h_next;
            fr_mode_reg   <= fr_mode_next;
            fr_half_reg   <= fr_half_next;
            fr_border_reg <= fr_border_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            ex_reg        <= ex_next;
            ey_reg        <= ey_next;
            ptr_reg       <= ptr_next;
            ctl_reg.valid  <= adv;
            ctl_reg.emit   <= emit;
            ctl_reg.border <= border;
            ctl_reg.last   <= last;
            ctl_reg.mode   <= fr_mode_next;
        end
    end

    // Hold the column context for the back end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_mask_reg <= row_mask_next;
            col_mask_reg <= col_mask_next;
            pix_s1_reg   <= wr_px;
            ptr_s1_reg   <= ptr_reg;
        end
    end

    // Line store: one memory per ring line, written at the current line, all read at x
    for (genvar i = 0; i < NROW; i++)
    begin : g_line
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (real_px && (ptr_reg == KW'(i)))
                mem[x_reg] <= wr_px;
            if (adv)
                rd_reg <= mem[x_reg];
        end

        assign rd_vec[i] = rd_reg;
    end

    // Rotate ring lines into rows, newest row first
    always_comb
    begin
        logic [KW-1:0] li;
        li = '0;
        col_px[0] = pix_s1_reg;
        for (int r = 1; r < NROW; r++)
        begin
            li = (ptr_s1_reg >= KW'(r)) ? ptr_s1_reg - KW'(r) : ptr_s1_reg + KW'(NROW - r);
            col_px[r] = rd_vec[li];
        end
    end

    assign ctl      = ctl_reg;
    assign row_mask = row_mask_reg;
    assign col_mask = col_mask_reg;

endmodule

// ----- sv/rmbl_back.sv -----
// Back end: luma ranking of each column, window shift register and window selection.
// Depends on rmbl_pkg.
`timescale 1ns / 1ps

module rmbl_back #(
    parameter int MAX_KERNEL = rmbl_pkg::DEF_MAX_KERNEL,
    localparam int NROW      = 2 * ((MAX_KERNEL - 1) / 2) + 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rmbl_pkg::fe_ctl_t                    ctl,
    input  logic [NROW-1:0]                      row_mask,
    input  logic [NROW-1:0]                      col_mask,
    input  logic [NROW-1:0][rmbl_pkg::PIX_W-1:0] col_px,
    output logic                                 res_push,
    output rmbl_pkg::res_t                       res,
    output logic [1:0]                           inflight
);
    import rmbl_pkg::*;

    localparam int KW = $clog2(NROW);

    // Stage two: ranking keys per row
    fe_ctl_t           ctl2_reg, ctl3_reg;
    logic [NROW-1:0]   cmask2_reg, cmask3_reg, rvld2_reg;
    logic [CHAN_W-1:0] lkey2_reg [NROW];
    logic [PIX_W-1:0]  px2_reg [NROW];

    // Stage three: window of column winners, newest column first
    logic [CHAN_W-1:0] win_lkey_reg [NROW];
    logic [KW-1:0]     win_row_reg [NROW];
    logic [PIX_W-1:0]  win_px_reg [NROW];
    logic [NROW-1:0]   win_vld_reg;

    logic              col_found, win_found;
    logic [CHAN_W-1:0] col_lkey, best_lkey;
    logic [KW-1:0]     col_row, best_row;
    logic [PIX_W-1:0]  col_sel_px, best_px;

    // Rank rows by luma, inverted for erosion so larger is always better
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            for (int r = 0; r < NROW; r++)
            begin
                lkey2_reg[r] <= ctl.mode ?
                    ~luma3(SUM_W'(col_px[r][23:16]) + SUM_W'(col_px[r][15:8]) +
                           SUM_W'(col_px[r][7:0])) :
                    luma3(SUM_W'(col_px[r][23:16]) + SUM_W'(col_px[r][15:8]) +
                          SUM_W'(col_px[r][7:0]));
                px2_reg[r] <= col_px[r];
            end
            rvld2_reg  <= row_mask;
            cmask2_reg <= col_mask;
        end
    end

    // Pick the column winner; on a tie the upper row wins
    always_comb
    begin
        col_found  = 1'b0;
        col_lkey   = '0;
        col_row    = '0;
        col_sel_px = '0;
        for (int r = 0; r < NROW; r++)
        begin
            if (rvld2_reg[r] && (!col_found || (lkey2_reg[r] >= col_lkey)))
            begin
                col_found  = 1'b1;
                col_lkey   = lkey2_reg[r];
                col_row    = KW'(r);
                col_sel_px = px2_reg[r];
            end
        end
    end

    // Advance the window by one column
    always_ff @(posedge clk)
    begin
        if (ctl2_reg.valid)
        begin
            win_lkey_reg[0] <= col_lkey;
            win_row_reg[0]  <= col_row;
            win_px_reg[0]   <= col_sel_px;
            win_vld_reg[0]  <= col_found;
            for (int k = 1; k < NROW; k++)
            begin
                win_lkey_reg[k] <= win_lkey_reg[k-1];
                win_row_reg[k]  <= win_row_reg[k-1];
                win_px_reg[k]   <= win_px_reg[k-1];
                win_vld_reg[k]  <= win_vld_reg[k-1];
            end
            cmask3_reg <= cmask2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Pick the window winner: higher key, then upper row, then leftmost column
    always_comb
    begin
        win_found = 1'b0;
        best_lkey = '0;
        best_row  = '0;
        best_px   = '0;
        for (int k = 0; k < NROW; k++)
        begin
            if (cmask3_reg[k] && win_vld_reg[k] &&
                (!win_found || ({win_lkey_reg[k], win_row_reg[k]} >= {best_lkey, best_row})))
            begin
                win_found = 1'b1;
                best_lkey = win_lkey_reg[k];
                best_row  = win_row_reg[k];
                best_px   = win_px_reg[k];
            end
        end
    end

    // Black out the border and send the result
    always_comb
    begin
        res.out_red    = ctl3_reg.border ? '0 : best_px[23:16];
        res.out_green  = ctl3_reg.border ? '0 : best_px[15:8];
        res.out_blue   = ctl3_reg.border ? '0 : best_px[7:0];
        res.last_pixel = ctl3_reg.last;
    end

    assign res_push = ctl3_reg.valid && ctl3_reg.emit;
    assign inflight = 2'(ctl2_reg.valid && ctl2_reg.emit) + 2'(ctl3_reg.valid && ctl3_reg.emit);

endmodule

// ----- sv/rmbl_res_queue.sv -----
// Result queue: short first-in first-out buffer in front of the result ports.
// Depends on rmbl_pkg.
`timescale 1ns / 1ps

module rmbl_res_queue (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  rmbl_pkg::res_t                        wr_data,
    input  logic                                  pop,
    output logic                                  empty,
    output rmbl_pkg::res_t                        rd_data,
    output logic [$clog2(rmbl_pkg::RQ_DEPTH):0]   count
);
    import rmbl_pkg::*;

    localparam int AW = $clog2(RQ_DEPTH);

    res_t          slot_reg [RQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          rd_en;

    assign empty   = (count_reg == '0);
    assign rd_en   = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

// ----- sv/rgb_morphology_by_luma_unit.sv -----
// Top level of the luma ranked color dilation and erosion unit.
// Depends on rmbl_pkg, rmbl_front, rmbl_back and rmbl_res_queue.
`timescale 1ns / 1ps

// Streaming 5x5 or 9x9 color dilation/erosion ranked by luma (r+g+b)/3. Pixels enter
// in raster order at one per clock; the block takes a new pixel every cycle as long as
// full is low. A result leaves half*W+half pixels after its own position (half = 2 or
// 4), and is queued after the pixel that completes its window passes ctl_reg, ctl2_reg
// and ctl3_reg. The front end holds 2*half_max+1 line memories of MAX_WIDTH pixels,
// one write and one read each per cycle; the back end ranks one column and one window
// per cycle. full rises only when the 8-entry result queue plus the three results in
// flight would overflow, so the rate is set by how fast results are popped.
// Configuration takes effect at the first pixel of the next frame. After the last
// pixel, push drain items (or any item) to flush the remaining results; the final one
// carries last_pixel. The line store needs no clear after reset.
module rgb_morphology_by_luma_unit #(
    parameter int MAX_WIDTH  = rmbl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = rmbl_pkg::DEF_MAX_KERNEL
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rmbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  rmbl_pkg::pix_in_t               pixel,
    output logic                            empty,
    input  logic                            pop,
    output rmbl_pkg::res_t                  result
);
    import rmbl_pkg::*;

    localparam int NROW = 2 * ((MAX_KERNEL - 1) / 2) + 1;

    fe_ctl_t                      fe_ctl;
    logic [NROW-1:0]              row_mask, col_mask;
    logic [NROW-1:0][PIX_W-1:0]   col_px;
    logic                         res_push;
    res_t                         res;
    logic [1:0]                   inflight;
    logic [$clog2(RQ_DEPTH):0]    q_count;

    assign cfg_ready = 1'b1;

    // Stall intake when the queue could not take every result in flight
    assign full = (32'(q_count) + 32'(inflight) + 32'(fe_ctl.valid && fe_ctl.emit)) >= RQ_DEPTH;

    rmbl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .ctl       (fe_ctl),
        .row_mask  (row_mask),
        .col_mask  (col_mask),
        .col_px    (col_px)
    );

    rmbl_back #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fe_ctl),
        .row_mask (row_mask),
        .col_mask (col_mask),
        .col_px   (col_px),
        .res_push (res_push),
        .res      (res),
        .inflight (inflight)
    );

    rmbl_res_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result),
        .count   (q_count)
    );

endmodule

// ----- sv/rmbl_checker.sv -----
// Port level checks for the luma ranked morphology unit, bound to its top level.
// Depends on rmbl_pkg and rgb_morphology_by_luma_unit_macros.svh.
`timescale 1ns / 1ps
`include "rgb_morphology_by_luma_unit_macros.svh"

module rmbl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input rmbl_pkg::res_t                  result
);
    // Queue comes out of reset empty
    `RMBL_ASSERT_ALWAYS(a_reset_empty, (!rst_n |=> empty), "queue not empty after reset")

    // A result shows up after the request that finished it passes ctl_reg, ctl2_reg and ctl3_reg
    `RMBL_ASSERT(a_result_latency, ($fell(empty) |-> $past(push && !full, 4)), "result without request")

    // An empty queue always leaves room for the pipeline
    `RMBL_ASSERT(a_empty_not_full, (empty |-> !full), "full while result queue empty")

    // A waiting result holds until popped
    `RMBL_ASSERT(a_result_hold, (!empty && !pop |=> !empty && $stable(result)), "result dropped")

endmodule

bind rgb_morphology_by_luma_unit rmbl_checker u_rmbl_checker (.*);

// ----- tb/sv/rgb_morphology_by_luma_unit_test.sv -----
// Self-checking testbench for rgb_morphology_by_luma_unit: frames of random and directed
// pixels, drain tails and register changes, checked against a behavioral predictor.
// Depends on rmbl_pkg and rgb_morphology_by_luma_unit.
`timescale 1ns / 1ps

module rgb_morphology_by_luma_unit_test;
    import rmbl_pkg::*;

    localparam int RING      = 10;
    localparam int LINE_LEN  = 2048;
    localparam int CYC_LIMIT = 1500000;
    localparam int SETTLE    = 16;

    // Predictor of the filtered pixel stream and store of the pending output pixels
    class luma_morph_scoreboard;
        logic [11:0] reg_w;
        logic [12:0] reg_h;
        logic        reg_mode;
        logic        reg_kernel;
        logic [2:0]  reg_border;
        int          fw, fh, fhalf, fborder;
        logic        fmode;
        int          col, row, emitted;
        logic [23:0] lines [RING*LINE_LEN];
        res_t        pending_pix [$];
        int          errors, checked, taken, frames;

        function new();
            reg_w      = RST_IMAGE_WIDTH;
            reg_h      = RST_IMAGE_HEIGHT;
            reg_mode   = 1'b0;
            reg_kernel = 1'b0;
            reg_border = RST_BORDER_WIDTH;
            col = 0; row = 0; emitted = 0;
            errors = 0; checked = 0; taken = 0; frames = 0;
            latch_geometry();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_IMAGE_WIDTH:    reg_w = d[11:0];
                CFG_IMAGE_HEIGHT:   reg_h = d[12:0];
                CFG_OPERATION_MODE: reg_mode = d[0];
                CFG_KERNEL_SELECT:  reg_kernel = d[0];
                CFG_BORDER_WIDTH:   reg_border = d[2:0];
                default: ;
            endcase
        endfunction

        function void latch_geometry();
            fw = reg_w;
            if (fw < IMAGE_WIDTH_MIN) fw = IMAGE_WIDTH_MIN;
            if (fw > LINE_LEN) fw = LINE_LEN;
            fh = reg_h;
            if (fh < IMAGE_HEIGHT_MIN) fh = IMAGE_HEIGHT_MIN;
            if (fh > IMAGE_HEIGHT_MAX) fh = IMAGE_HEIGHT_MAX;
            fmode   = reg_mode;
            fhalf   = reg_kernel ? KERNEL_LARGE / 2 : KERNEL_SMALL / 2;
            fborder = reg_border;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0 && emitted == 0;
        endfunction

        function bit pixels_done();
            return row * fw + col >= fw * fh;
        endfunction

        // Rank the window around the next output position by luma
        function void produce();
            int          ox, oy, yy, xx, best, lum;
            logic [23:0] pick, px;
            res_t        r;
            ox = emitted % fw;
            oy = emitted / fw;
            pick = '0;
            if (!(ox < fborder || ox + fborder >= fw || oy < fborder || oy + fborder >= fh))
            begin
                best = fmode ? 256 : -1;
                for (int dy = -fhalf; dy <= fhalf; dy++)
                begin
                    yy = oy + dy;
                    if (yy < 0 || yy >= fh) continue;
                    for (int dx = -fhalf; dx <= fhalf; dx++)
                    begin
                        xx = ox + dx;
                        if (xx < 0 || xx >= fw) continue;
                        px = lines[(yy % RING) * LINE_LEN + xx];
                        lum = (int'(px[23:16]) + int'(px[15:8]) + int'(px[7:0])) / 3;
                        if (fmode ? (lum < best) : (lum > best))
                        begin
                            best = lum;
                            pick = px;
                        end
                    end
                end
            end
            r.out_red    = pick[23:16];
            r.out_green  = pick[15:8];
            r.out_blue   = pick[7:0];
            r.last_pixel = (emitted + 1 == fw * fh);
            pending_pix.push_back(r);
            if (emitted + 1 >= fw * fh)
            begin
                emitted = 0; col = 0; row = 0;
                frames++;
            end
            else
                emitted++;
        endfunction

        // Note an accepted request; returns 1 unless the block ignores it
        function bit note_request(pix_in_t p);
            int acc;
            if (!p.drain && at_frame_start()) latch_geometry();
            acc = row * fw + col;
            if (!p.drain && acc < fw * fh)
            begin
                lines[(row % RING) * LINE_LEN + col] = {p.in_red, p.in_green, p.in_blue};
                col++;
                if (col >= fw)
                begin
                    col = 0;
                    row++;
                end
                if (acc >= fhalf * fw + fhalf) produce();
                taken++;
                return 1;
            end
            if (acc >= fw * fh)
            begin
                produce();
                taken++;
                return 1;
            end
            return 0;
        endfunction

        function void check_pixel(res_t got);
            res_t exp;
            if (pending_pix.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output pixel %h", $realtime, got);
                return;
            end
            exp = pending_pix.pop_front();
            checked++;
            if (got.out_red !== exp.out_red || got.out_green !== exp.out_green ||
                got.out_blue !== exp.out_blue || got.last_pixel !== exp.last_pixel)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: pixel %0d expected r=%h g=%h b=%h last=%b got r=%h g=%h b=%h last=%b",
                             $realtime, checked, exp.out_red, exp.out_green, exp.out_blue,
                             exp.last_pixel, got.out_red, got.out_green, got.out_blue,
                             got.last_pixel);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    pix_in_t               pixel;
    logic                  empty;
    logic                  pop;
    res_t                  result;

    luma_morph_scoreboard sb;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_cycles;
    int                   cycle_count;
    int                   saw_full;

    rgb_morphology_by_luma_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (push && full) saw_full++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drain results: check each popped pixel, then stall or hold off as asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) sb.check_pixel(result);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write all five registers back to back, then drop valid
    task automatic write_regs(int w, int h, int mode, int kern, int border);
        int vals [5];
        logic [CFG_IDX_W-1:0] idx [5];
        vals = '{w, h, mode, kern, border};
        idx  = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_OPERATION_MODE,
                 CFG_KERNEL_SELECT, CFG_BORDER_WIDTH};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= CFG_DATA_W'(vals[i]);
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(idx[i], CFG_DATA_W'(vals[i]));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_pixel(pix_in_t p);
        pixel <= p;
        push  <= 1'b1;
        do @(posedge clk); while (full);
        void'(sb.note_request(p));
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic pix_in_t rand_pixel();
        pix_in_t p;
        logic [7:0] v;
        p.in_red   = 8'($urandom);
        p.in_green = 8'($urandom);
        p.in_blue  = 8'($urandom);
        p.drain    = 1'b0;
        case ($urandom_range(3))
            0: ;
            1:
            begin
                p.in_red   = $urandom_range(1) ? 8'hff : 8'h00;
                p.in_green = $urandom_range(1) ? 8'hff : 8'h00;
                p.in_blue  = $urandom_range(1) ? 8'hff : 8'h00;
            end
            2:
            begin
                v = 8'($urandom);
                p.in_red = v; p.in_green = v; p.in_blue = v;
            end
            default:
            begin
                // small spread so equal lumas with different colors show up
                v = 8'($urandom_range(252));
                p.in_red   = 8'(v + $urandom_range(3));
                p.in_green = 8'(v + $urandom_range(3));
                p.in_blue  = 8'(v + $urandom_range(3));
            end
        endcase
        return p;
    endfunction

    task automatic wait_idle();
        while (sb.pending_pix.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Push one full frame plus its drain tail; optional hold-off and pause points
    task automatic run_frame(int hold_at, int pause_at);
        pix_in_t p;
        int      k;
        bit      started;
        logic [23:0] corner [12];
        corner = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h010101,
                   24'h020000, 24'h000002, 24'hfffffe, 24'hfefeff, 24'h808080, 24'h7f8081};
        k = 0;
        started = 0;
        // stray drain between frames
        if ($urandom_range(3) == 0)
        begin
            p = rand_pixel();
            p.drain = 1'b1;
            send_pixel(p);
        end
        do
        begin
            p = rand_pixel();
            if (sb.frames == 0 && k < 12) {p.in_red, p.in_green, p.in_blue} = corner[k];
            if (!sb.pixels_done())
            begin
                if (started && $urandom_range(99) < 3) p.drain = 1'b1;
            end
            else if ($urandom_range(99) < 85)
                p.drain = 1'b1;
            if (k == hold_at) hold_cycles = 400;
            if (k == pause_at && sb.pending_pix.size() != 0)
            begin
                push <= 1'b0;
                while (sb.pending_pix.size() != 0) @(posedge clk);
            end
            send_pixel(p);
            started = 1;
            k++;
        end
        while (!sb.at_frame_start());
        push <= 1'b0;
        wait_idle();
    endtask

    task automatic set_idle(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
    endtask

    initial
    begin
        int phase;
        sb = new();
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        push           <= 1'b0;
        pixel          <= '0;
        pop            <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        cycle_count    = 0;
        saw_full       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed settings: smallest frame, both modes and kernels, border extremes
        set_idle(0);
        write_regs(16, 16, 0, 0, 0);
        run_frame(40, -1);
        set_idle(1);
        write_regs(16, 16, 1, 1, 4);
        run_frame(-1, 100);
        set_idle(2);
        write_regs(20, 17, 0, 1, 7);
        run_frame(-1, -1);
        set_idle(3);
        write_regs(0, 0, 1, 0, 2);
        run_frame(-1, -1);

        // Random small frames until about 1500 requests have gone in
        phase = 1;
        while (sb.taken < 1500)
        begin
            set_idle(phase);
            write_regs($urandom_range(16, 24), $urandom_range(16, 18), $urandom_range(1),
                       $urandom_range(1), $urandom_range(7));
            run_frame((phase % 5 == 2) ? 150 : -1, (phase % 5 == 4) ? 120 : -1);
            phase++;
        end

        wait_idle();
        $display("Covered %0d frames, %0d requests, %0d output pixels checked, full seen %0d cycles.",
                 sb.frames, sb.taken, sb.checked, saw_full);
        $display("Both modes, both kernels, borders 0..7, small frames, low geometry clamped.");
        if (sb.errors == 0 && sb.pending_pix.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rmbl_pkg.sv
sv/rmbl_front.sv
sv/rmbl_back.sv
sv/rmbl_res_queue.sv
sv/rgb_morphology_by_luma_unit.sv
sv/rmbl_checker.sv
tb/sv/rgb_morphology_by_luma_unit_test.sv
